// ===== sv/lbft_pkg.sv =====
// Package for the log-block flash translation block.
// Holds the transaction types, geometry constants and log-row helpers.
// No dependencies.
`default_nettype none
package lbft_pkg;

   localparam int PAGE_BITS  = 3;
   localparam int BLOCK_BITS = 6;
   localparam int PAGES      = 8;
   localparam int BLOCKS     = 64;
   localparam int ENT_BITS   = 4;
   localparam int ROW_BITS   = PAGES * ENT_BITS;

   localparam logic [BLOCK_BITS-1:0] CLEAN_BLOCK = 6'd63;
   localparam logic [ENT_BITS-1:0]   ENTRY_EMPTY = 4'hF;
   localparam logic [PAGE_BITS-1:0]  LAST_PAGE   = 3'd7;
   localparam logic [BLOCK_BITS-1:0] LAST_BLOCK  = 6'd63;

   localparam logic [2:0] K_HREAD  = 3'd0;
   localparam logic [2:0] K_HWRITE = 3'd1;
   localparam logic [2:0] K_MREAD  = 3'd2;
   localparam logic [2:0] K_MWRITE = 3'd3;
   localparam logic [2:0] K_ERASE  = 3'd4;

   typedef struct packed {
      logic       func;
      logic [8:0] lba;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] phys_block;
      logic [2:0] phys_page;
      logic       status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                  found;
      logic [PAGE_BITS-1:0]  idx;
   } hit_type;

   typedef struct packed {
      logic [BLOCK_BITS-1:0] addr;
      logic                  pw_we;
      logic [PAGES-1:0]      pw_row;
      logic                  lbd_we;
      logic [BLOCK_BITS-1:0] lbd;
      logic                  ent_we;
      logic [ROW_BITS-1:0]   ent_row;
      logic                  bind_we;
   } store_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic [PAGES-1:0]      pw_row;
      logic [ROW_BITS-1:0]   ent_row;
      logic [BLOCK_BITS-1:0] lbd;
      logic                  bound;
   } store_rsp_type;

   function automatic hit_type newest_copy(logic [ROW_BITS-1:0] row,
                                           logic [PAGE_BITS-1:0] off);
      hit_type h;
      h = '0;
      for (int i = 0; i < PAGES; i++) begin
         if (row[i*ENT_BITS +: ENT_BITS] == {1'b0, off}) begin
            h.found = 1'b1;
            h.idx   = PAGE_BITS'(i);
         end
      end
      return h;
   endfunction

   function automatic hit_type first_empty(logic [ROW_BITS-1:0] row);
      hit_type h;
      h = '0;
      for (int i = PAGES - 1; i >= 0; i--) begin
         if (row[i*ENT_BITS +: ENT_BITS] == ENTRY_EMPTY) begin
            h.found = 1'b1;
            h.idx   = PAGE_BITS'(i);
         end
      end
      return h;
   endfunction

   function automatic logic [ROW_BITS-1:0] set_entry(logic [ROW_BITS-1:0] row,
                                                     logic [PAGE_BITS-1:0] idx,
                                                     logic [PAGE_BITS-1:0] off);
      logic [ROW_BITS-1:0] r;
      r = row;
      r[idx*ENT_BITS +: ENT_BITS] = {1'b0, off};
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/log_block_flash_translation.sv =====
// Top level of the log-block flash translation block: sequencer and result register.
// Depends on lbft_pkg and lbft_store.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | req_type (func, lba)
//   rsp     | out       | rsp_valid/stall  | rsp_type (kind, block, page, status, last)
//   csr     | in        | csr_valid/ready  | data_block_count, 6 bits
//
// A simple transaction passes through the states WAIT and DEC from accept to the next
// accept; its one result is registered in DEC. A merge copies each written page of the
// block out to the clean block and back, erases the data, log and clean blocks, and ends
// with the host write. Reset clears the written-page memory row by row; no request is
// taken meanwhile. Stalls on rsp hold the sequencer in place.
`default_nettype none
module log_block_flash_translation (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire lbft_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output lbft_pkg::rsp_type      rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [5:0]              csr_data
);
   import lbft_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WAIT = 4'd1;
   localparam logic [3:0] S_DEC  = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_ME1  = 4'd4;
   localparam logic [3:0] S_ME2  = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_ME3  = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic                  func_ff;
   logic [8:0]            lba_ff;
   logic [5:0]            dbc_ff;
   logic [5:0]            used_ff, used_in;
   logic [PAGE_BITS-1:0]  cnt_ff, cnt_in;
   logic                  sub_ff, sub_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   store_cmd_type         cmd;
   store_rsp_type         st;

   logic [BLOCK_BITS-1:0] blk;
   logic [PAGE_BITS-1:0]  off;
   logic                  accept, can_emit, emit;
   rsp_type               res;
   hit_type               nc_off, nc_cnt, fe;
   logic [6:0]            reserve_sum;
   logic [ROW_BITS-1:0]   fresh_row;

   lbft_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (st)
   );

   assign blk         = lba_ff[8:3];
   assign off         = lba_ff[2:0];
   assign req_stall   = (state_ff != S_IDLE) || st.busy;
   assign accept      = req_valid && !req_stall;
   assign can_emit    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign nc_off      = newest_copy(st.ent_row, off);
   assign nc_cnt      = newest_copy(st.ent_row, cnt_ff);
   assign fe          = first_empty(st.ent_row);
   assign reserve_sum = {1'b0, dbc_ff} + {1'b0, used_ff};
   assign fresh_row   = set_entry({PAGES{ENTRY_EMPTY}}, '0, off);

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      cnt_in      = cnt_ff;
      sub_in      = sub_ff;
      emit        = 1'b0;
      res         = '0;
      cmd         = '0;
      cmd.addr    = blk;
      cmd.pw_row  = st.pw_row | (PAGES'(1) << off);
      cmd.lbd     = reserve_sum[5:0];
      cmd.ent_row = fresh_row;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_WAIT;
         end
         S_WAIT: state_in = S_DEC;
         S_DEC: begin
            res.last = 1'b1;
            if (func_ff) begin
               res.kind = K_HWRITE;
               if (blk >= dbc_ff) begin
                  res.status = 1'b1;
                  emit = can_emit;
               end else if (!st.pw_row[off]) begin
                  res.phys_block = blk;
                  res.phys_page  = off;
                  emit = can_emit;
                  cmd.pw_we = emit;
               end else if (st.bound) begin
                  if (fe.found) begin
                     res.phys_block = st.lbd;
                     res.phys_page  = fe.idx;
                     emit = can_emit;
                     cmd.ent_we  = emit;
                     cmd.ent_row = set_entry(st.ent_row, fe.idx, off);
                  end else begin
                     state_in = S_M1;
                     cnt_in   = '0;
                     sub_in   = 1'b0;
                  end
               end else if (reserve_sum >= 7'(CLEAN_BLOCK)) begin
                  res.status = 1'b1;
                  emit = can_emit;
               end else begin
                  res.phys_block = reserve_sum[5:0];
                  emit = can_emit;
                  cmd.lbd_we  = emit;
                  cmd.bind_we = emit;
                  cmd.ent_we  = emit;
                  if (emit) used_in = used_ff + 1'b1;
               end
            end else begin
               res.kind = K_HREAD;
               emit = can_emit;
               if (!st.pw_row[off]) begin
                  res.status = 1'b1;
               end else if (st.bound && nc_off.found) begin
                  res.phys_block = st.lbd;
                  res.phys_page  = nc_off.idx;
               end else begin
                  res.phys_block = blk;
                  res.phys_page  = off;
               end
            end
            if (emit) state_in = S_IDLE;
         end
         S_M1, S_M3: begin
            if ((state_ff == S_M1) ? (nc_cnt.found || st.pw_row[cnt_ff])
                                   : st.pw_row[cnt_ff]) begin
               emit = can_emit;
               if (!sub_ff) begin
                  res.kind = K_MREAD;
                  if (state_ff == S_M3) begin
                     res.phys_block = CLEAN_BLOCK;
                     res.phys_page  = cnt_ff;
                  end else if (nc_cnt.found) begin
                     res.phys_block = st.lbd;
                     res.phys_page  = nc_cnt.idx;
                  end else begin
                     res.phys_block = blk;
                     res.phys_page  = cnt_ff;
                  end
               end else begin
                  res.kind       = K_MWRITE;
                  res.phys_block = (state_ff == S_M1) ? CLEAN_BLOCK : blk;
                  res.phys_page  = cnt_ff;
               end
               if (emit) sub_in = !sub_ff;
            end
            if ((emit && sub_ff) || !((state_ff == S_M1)
                  ? (nc_cnt.found || st.pw_row[cnt_ff]) : st.pw_row[cnt_ff])) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_PAGE) state_in = (state_ff == S_M1) ? S_ME1 : S_ME3;
            end
         end
         S_ME1, S_ME2, S_ME3: begin
            res.kind = K_ERASE;
            res.phys_block = (state_ff == S_ME1) ? blk :
                             (state_ff == S_ME2) ? st.lbd : CLEAN_BLOCK;
            emit = can_emit;
            if (emit) begin
               state_in = (state_ff == S_ME1) ? S_ME2 :
                          (state_ff == S_ME2) ? S_M3 : S_FIN;
               cnt_in = '0;
               sub_in = 1'b0;
            end
         end
         S_FIN: begin
            res.kind       = K_HWRITE;
            res.phys_block = st.lbd;
            res.last       = 1'b1;
            emit = can_emit;
            cmd.ent_we = emit;
            if (emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dbc_ff       <= 6'd56;
         used_ff      <= '0;
         cnt_ff       <= '0;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         sub_ff   <= sub_in;
         if (csr_valid && csr_ready) dbc_ff <= csr_data;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_data.func;
         lba_ff  <= req_data.lba;
      end
      if (emit) rsp_ff <= res;
   end

endmodule
`default_nettype wire

// ===== sv/lbft_store.sv =====
// State memories: written-page rows, log block numbers, log page entries, bind bits.
// Depends on lbft_pkg. Clears the written-page memory after reset.
`default_nettype none
module lbft_store (
   input  wire                         clock,
   input  wire                         reset,
   input  wire lbft_pkg::store_cmd_type cmd,
   output lbft_pkg::store_rsp_type      rsp
);
   import lbft_pkg::*;

   logic [PAGES-1:0]      pw_mem  [BLOCKS];
   logic [BLOCK_BITS-1:0] lbd_mem [BLOCKS];
   logic [ROW_BITS-1:0]   ent_mem [BLOCKS];

   logic [BLOCKS-1:0]     bound_ff;
   logic                  clr_ff;
   logic [BLOCK_BITS-1:0] clr_cnt_ff;
   logic [PAGES-1:0]      pw_rd_ff;
   logic [BLOCK_BITS-1:0] lbd_rd_ff;
   logic [ROW_BITS-1:0]   ent_rd_ff;
   logic                  bound_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         bound_ff   <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_BLOCK) clr_ff <= 1'b0;
         end
         if (cmd.bind_we) bound_ff[cmd.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) pw_mem[clr_cnt_ff] <= '0;
      else if (cmd.pw_we) pw_mem[cmd.addr] <= cmd.pw_row;
      if (cmd.lbd_we) lbd_mem[cmd.addr] <= cmd.lbd;
      if (cmd.ent_we) ent_mem[cmd.addr] <= cmd.ent_row;
      pw_rd_ff    <= pw_mem[cmd.addr];
      lbd_rd_ff   <= lbd_mem[cmd.addr];
      ent_rd_ff   <= ent_mem[cmd.addr];
      bound_rd_ff <= bound_ff[cmd.addr];
   end

   assign rsp.busy    = clr_ff;
   assign rsp.pw_row  = pw_rd_ff;
   assign rsp.ent_row = ent_rd_ff;
   assign rsp.lbd     = lbd_rd_ff;
   assign rsp.bound   = bound_rd_ff;

endmodule
`default_nettype wire

// ===== test/log_block_flash_translation_tb.sv =====
// Testbench for log_block_flash_translation: host reads and writes, log binding, merges.
// Predicts the flash command stream in SystemVerilog and checks every result transaction.
// Depends on lbft_pkg and log_block_flash_translation.
`default_nettype none
module log_block_flash_translation_tb;
   import lbft_pkg::*;

   localparam int STALL_LIMIT = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [5:0] csr_data = '0;

   log_block_flash_translation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   logic [5:0]          data_blocks;
   bit                  page_used [512];
   bit                  has_log [64];
   logic [5:0]          log_of [64];
   logic [3:0]          log_entry [512];
   int                  reserve_taken;
   rsp_type             flash_cmds [$];
   int                  errors = 0;
   int                  send_idle = 0;
   int                  stall_idle = 0;
   int                  stall_hold = 0;
   int                  quiet_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void emit(ref rsp_type cmds [$], input logic [2:0] k,
                                input logic [5:0] b, input logic [2:0] p, input logic s);
      rsp_type r;
      r.kind = k;
      r.phys_block = b;
      r.phys_page = p;
      r.status = s;
      r.last = 1'b0;
      cmds.push_back(r);
   endfunction

   function automatic int newest_log_page(int blk, logic [2:0] off);
      for (int i = PAGES - 1; i >= 0; i--)
         if (log_entry[blk*PAGES + i] == {1'b0, off}) return i;
      return -1;
   endfunction

   function automatic void translate_request(logic func, logic [8:0] lba);
      rsp_type    cmds [$];
      int         blk;
      logic [2:0] off;
      int         idx;
      logic [5:0] lb;
      blk = lba / PAGES;
      off = lba[2:0];
      if (func) begin
         if (int'(lba) >= int'(data_blocks) * PAGES) begin
            emit(cmds, K_HWRITE, '0, '0, 1'b1);
         end else if (!page_used[lba]) begin
            page_used[lba] = 1'b1;
            emit(cmds, K_HWRITE, blk[5:0], off, 1'b0);
         end else if (has_log[blk]) begin
            idx = -1;
            for (int i = PAGES - 1; i >= 0; i--)
               if (log_entry[blk*PAGES + i] == ENTRY_EMPTY) idx = i;
            lb = log_of[blk];
            if (idx >= 0) begin
               log_entry[blk*PAGES + idx] = {1'b0, off};
               emit(cmds, K_HWRITE, lb, idx[2:0], 1'b0);
            end else begin
               for (int o = 0; o < PAGES; o++) begin
                  idx = newest_log_page(blk, o[2:0]);
                  if (idx >= 0) begin
                     emit(cmds, K_MREAD, lb, idx[2:0], 1'b0);
                     emit(cmds, K_MWRITE, CLEAN_BLOCK, o[2:0], 1'b0);
                  end else if (page_used[blk*PAGES + o]) begin
                     emit(cmds, K_MREAD, blk[5:0], o[2:0], 1'b0);
                     emit(cmds, K_MWRITE, CLEAN_BLOCK, o[2:0], 1'b0);
                  end
               end
               emit(cmds, K_ERASE, blk[5:0], '0, 1'b0);
               emit(cmds, K_ERASE, lb, '0, 1'b0);
               for (int o = 0; o < PAGES; o++) begin
                  if (page_used[blk*PAGES + o]) begin
                     emit(cmds, K_MREAD, CLEAN_BLOCK, o[2:0], 1'b0);
                     emit(cmds, K_MWRITE, blk[5:0], o[2:0], 1'b0);
                  end
               end
               emit(cmds, K_ERASE, CLEAN_BLOCK, '0, 1'b0);
               for (int i = 0; i < PAGES; i++) log_entry[blk*PAGES + i] = ENTRY_EMPTY;
               log_entry[blk*PAGES] = {1'b0, off};
               emit(cmds, K_HWRITE, lb, '0, 1'b0);
            end
         end else if (int'(data_blocks) + reserve_taken >= BLOCKS - 1) begin
            emit(cmds, K_HWRITE, '0, '0, 1'b1);
         end else begin
            lb = 6'(int'(data_blocks) + reserve_taken);
            log_of[blk] = lb;
            reserve_taken++;
            has_log[blk] = 1'b1;
            for (int i = 0; i < PAGES; i++) log_entry[blk*PAGES + i] = ENTRY_EMPTY;
            log_entry[blk*PAGES] = {1'b0, off};
            emit(cmds, K_HWRITE, lb, '0, 1'b0);
         end
      end else begin
         idx = -1;
         if (!page_used[lba]) begin
            emit(cmds, K_HREAD, '0, '0, 1'b1);
         end else begin
            if (has_log[blk]) idx = newest_log_page(blk, off);
            if (idx >= 0) emit(cmds, K_HREAD, log_of[blk], idx[2:0], 1'b0);
            else emit(cmds, K_HREAD, blk[5:0], off, 1'b0);
         end
      end
      cmds[cmds.size()-1].last = 1'b1;
      foreach (cmds[i]) flash_cmds.push_back(cmds[i]);
   endfunction

   task automatic send_request(logic func, logic [8:0] lba);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data <= '{func: func, lba: lba};
      do @(posedge clock); while (req_stall);
      translate_request(func, lba);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (flash_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_data_blocks(logic [5:0] value);
      drain();
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      data_blocks = value;
   endtask

   task automatic send_random(int count, int hot_blocks);
      logic [8:0] lba;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7)
            lba = 9'($urandom_range(hot_blocks - 1) * PAGES + $urandom_range(PAGES - 1));
         else
            lba = 9'($urandom_range(511));
         send_request($urandom_range(99) < 75, lba);
      end
   endtask

   task automatic test_directed();
      send_request(1'b0, 9'd0);
      for (int n = 0; n < 10; n++) send_request(1'b1, 9'd3);
      send_request(1'b0, 9'd3);
      send_request(1'b1, 9'd0);
      send_request(1'b0, 9'd0);
      send_request(1'b0, 9'd2);
      send_request(1'b1, 9'd447);
      send_request(1'b1, 9'd448);
      send_request(1'b1, 9'd511);
      send_request(1'b0, 9'd511);
      send_request(1'b0, 9'd447);
      send_request(1'b1, 9'd447);
      send_request(1'b0, 9'd447);
   endtask

   task automatic test_log_merge();
      send_random(50, 4);
   endtask

   task automatic test_reserve_limit();
      write_data_blocks(6'd62);
      send_random(30, 12);
   endtask

   task automatic test_backpressure();
      stall_hold = 400;
      send_idle = 0;
      send_random(20, 3);
      drain();
      send_random(5, 3);
   endtask

   task automatic test_small_config();
      write_data_blocks(6'd1);
      send_random(15, 1);
      write_data_blocks(6'd0);
      send_random(6, 2);
      write_data_blocks(6'd20);
      send_random(20, 22);
   endtask

   always @(posedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flash_cmds.size() == 0) begin
            $error("unexpected result transaction %h", rsp_data);
            errors++;
         end else begin
            want = flash_cmds.pop_front();
            if (rsp_data.kind != want.kind) begin
               $error("kind: expected %0d actual %0d", want.kind, rsp_data.kind);
               errors++;
            end
            if (rsp_data.phys_block != want.phys_block) begin
               $error("phys_block: expected %0d actual %0d", want.phys_block,
                      rsp_data.phys_block);
               errors++;
            end
            if (rsp_data.phys_page != want.phys_page) begin
               $error("phys_page: expected %0d actual %0d", want.phys_page,
                      rsp_data.phys_page);
               errors++;
            end
            if (rsp_data.status != want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.last != want.last) begin
               $error("last: expected %0d actual %0d", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      data_blocks = 6'd56;
      reserve_taken = 0;
      foreach (page_used[i]) page_used[i] = 1'b0;
      foreach (has_log[i]) has_log[i] = 1'b0;
      foreach (log_of[i]) log_of[i] = '0;
      foreach (log_entry[i]) log_entry[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle = 27;
      stall_idle = 79;
      test_directed();
      test_log_merge();
      send_idle = 79;
      stall_idle = 27;
      test_reserve_limit();
      test_backpressure();
      send_idle = 0;
      stall_idle = 0;
      test_small_config();
      drain();
      repeat (60) @(posedge clock);
      if (errors == 0 && flash_cmds.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
